// ===== sv/sefp_pkg.sv =====
// ----------------------------------------------------------------------------
// sefp_pkg
// Shared types, codes and the byte-wide CRC-16 update of the frame parser.
// ----------------------------------------------------------------------------
package sefp_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error causes
    localparam logic [1:0] CAUSE_LEN_HEX   = 2'd0;
    localparam logic [1:0] CAUSE_LEN_RANGE = 2'd1;
    localparam logic [1:0] CAUSE_CRC_HEX   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_VALUE    = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd1;
    localparam logic [1:0] CFG_CRC_START     = 2'd2;

    localparam logic [7:0]  SYNC_RESET      = 8'h55;
    localparam logic [11:0] MAX_LEN_RESET   = 12'd4095;
    localparam logic [15:0] CRC_START_RESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [11:0] MIN_FRAME_LEN   = 12'd9;
    localparam logic [12:0] CRC_FIELD_LEN   = 13'd4;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [11:0] max_frame_len;
        logic [15:0] crc_seed;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [10:0] payload_count;
        logic [11:0] frame_len;
        logic [15:0] crc_got;
        logic [15:0] crc_calc;
        logic        crc_match;
        logic [1:0]  error_cause;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/sefp_byte_if.sv =====
// ----------------------------------------------------------------------------
// sefp_byte_if
// Valid/ready channel carrying one received raw byte per word.
// ----------------------------------------------------------------------------
interface sefp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sefp_result_if.sv =====
// ----------------------------------------------------------------------------
// sefp_result_if
// Valid/ready channel carrying one parser result per word.
// ----------------------------------------------------------------------------
interface sefp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [10:0] payload_count;
    logic [11:0] frame_len;
    logic [15:0] crc_got;
    logic [15:0] crc_calc;
    logic        crc_match;
    logic [1:0]  error_cause;

    modport source (output valid, output kind, output data, output payload_count,
                    output frame_len, output crc_got, output crc_calc, output crc_match,
                    output error_cause, input ready);
    modport sink   (input valid, input kind, input data, input payload_count,
                    input frame_len, input crc_got, input crc_calc, input crc_match,
                    input error_cause, output ready);
endinterface

// ===== sv/sefp_parser.sv =====
// ----------------------------------------------------------------------------
// sefp_parser
// Frame state and one-byte parse step: header, unstuffing, CRC and checks.
// ----------------------------------------------------------------------------
module sefp_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  sefp_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output sefp_pkg::t_result    o_res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_TYPE    = 4'd1;
    localparam logic [3:0] PH_LEN0    = 4'd2;
    localparam logic [3:0] PH_LEN1    = 4'd3;
    localparam logic [3:0] PH_LEN2    = 4'd4;
    localparam logic [3:0] PH_PAYLOAD = 4'd5;
    localparam logic [3:0] PH_ESC     = 4'd6;
    localparam logic [3:0] PH_CRC1    = 4'd7;
    localparam logic [3:0] PH_CRC2    = 4'd8;
    localparam logic [3:0] PH_CRC3    = 4'd9;
    localparam logic [3:0] PH_DONE    = 4'd10;
    localparam logic [3:0] PH_ERROR   = 4'd11;

    localparam logic [11:0] KEEP_LIMIT = 12'(MAX_PAYLOAD);

    // bit 4 set: not a hex character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= "0" && c <= "9") begin
            v = 5'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            v = 5'(c - "A" + 8'd10);
        end else if (c >= "a" && c <= "f") begin
            v = 5'(c - "a" + 8'd10);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    logic [3:0]  r_phase,   n_phase;
    logic [7:0]  r_type,    n_type;
    logic        r_len_bad, n_len_bad;
    logic        r_crc_bad, n_crc_bad;
    logic [11:0] r_decl,    n_decl;
    logic [12:0] r_raw,     n_raw;
    logic [11:0] r_kept,    n_kept;
    logic [15:0] r_crc,     n_crc;
    logic [11:0] r_crc_dig, n_crc_dig;

    logic        is_sync;
    logic [4:0]  hv;
    logic [3:0]  digit;
    logic [11:0] new_decl;
    logic [15:0] crc_next;
    logic [15:0] crc_got;
    logic        keep_ok;

    assign is_sync  = (i_byte == i_cfg.sync_value);
    assign hv       = hex_val(i_byte);
    assign digit    = hv[4] ? 4'd0 : hv[3:0];
    assign new_decl = {r_decl[7:0], digit};
    assign crc_next = sefp_pkg::crc_byte(r_crc, i_byte);
    assign crc_got  = {r_crc_dig, digit};
    assign keep_ok  = (r_kept < KEEP_LIMIT);

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len_bad   = r_len_bad;
        n_crc_bad   = r_crc_bad;
        n_decl      = r_decl;
        n_raw       = r_raw;
        n_kept      = r_kept;
        n_crc       = r_crc;
        n_crc_dig   = r_crc_dig;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.data          = r_type;
        o_res.payload_count = r_kept[10:0];
        o_res.frame_len     = r_decl;

        unique case (r_phase) inside
            PH_TYPE: begin
                n_type  = i_byte;
                n_crc   = crc_next;
                n_raw   = r_raw + 13'd1;
                n_phase = PH_LEN0;
            end
            PH_LEN0, PH_LEN1, PH_LEN2: begin
                n_crc     = crc_next;
                n_raw     = r_raw + 13'd1;
                n_decl    = new_decl;
                n_len_bad = r_len_bad | hv[4];
                n_phase   = r_phase + 4'd1;
                if (r_phase == PH_LEN2) begin
                    if (r_len_bad || hv[4]) begin
                        n_decl            = '0;
                        n_phase           = PH_ERROR;
                        o_res_valid       = 1'b1;
                        o_res.kind        = sefp_pkg::KIND_ERROR;
                        o_res.frame_len   = '0;
                        o_res.error_cause = sefp_pkg::CAUSE_LEN_HEX;
                    end else if (new_decl < sefp_pkg::MIN_FRAME_LEN ||
                                 new_decl > i_cfg.max_frame_len) begin
                        n_phase           = PH_ERROR;
                        o_res_valid       = 1'b1;
                        o_res.kind        = sefp_pkg::KIND_ERROR;
                        o_res.frame_len   = new_decl;
                        o_res.error_cause = sefp_pkg::CAUSE_LEN_RANGE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_raw >= {1'b0, r_decl} - sefp_pkg::CRC_FIELD_LEN) begin
                    n_crc_bad = r_crc_bad | hv[4];
                    n_crc_dig = {r_crc_dig[7:0], digit};
                    n_phase   = PH_CRC1;
                end else begin
                    n_crc = crc_next;
                    n_raw = r_raw + 13'd1;
                    if (is_sync) begin
                        n_phase = PH_ESC;
                    end else if (keep_ok) begin
                        n_kept              = r_kept + 12'd1;
                        o_res_valid         = 1'b1;
                        o_res.kind          = sefp_pkg::KIND_PAYLOAD;
                        o_res.data          = i_byte;
                        o_res.payload_count = n_kept[10:0];
                    end
                end
            end
            PH_ESC: begin
                if (is_sync) begin
                    n_crc   = crc_next;
                    n_raw   = r_raw + 13'd1;
                    n_phase = PH_PAYLOAD;
                    if (keep_ok) begin
                        n_kept              = r_kept + 12'd1;
                        o_res_valid         = 1'b1;
                        o_res.kind          = sefp_pkg::KIND_PAYLOAD;
                        o_res.data          = i_byte;
                        o_res.payload_count = n_kept[10:0];
                    end
                end else begin
                    // broken escape: the sync opens a new frame, this word is its type
                    n_type    = i_byte;
                    n_len_bad = 1'b0;
                    n_crc_bad = 1'b0;
                    n_decl    = '0;
                    n_raw     = 13'd2;
                    n_kept    = '0;
                    n_crc     = sefp_pkg::crc_byte(i_cfg.crc_seed, i_byte);
                    n_crc_dig = '0;
                    n_phase   = PH_LEN0;
                end
            end
            PH_CRC1, PH_CRC2: begin
                n_crc_bad = r_crc_bad | hv[4];
                n_crc_dig = {r_crc_dig[7:0], digit};
                n_phase   = r_phase + 4'd1;
            end
            PH_CRC3: begin
                o_res_valid = 1'b1;
                if (hv[4] || r_crc_bad) begin
                    n_phase           = PH_ERROR;
                    o_res.kind        = sefp_pkg::KIND_ERROR;
                    o_res.error_cause = sefp_pkg::CAUSE_CRC_HEX;
                end else begin
                    n_phase         = PH_DONE;
                    o_res.kind      = sefp_pkg::KIND_DONE;
                    o_res.crc_got   = crc_got;
                    o_res.crc_calc  = r_crc;
                    o_res.crc_match = (crc_got == r_crc);
                end
            end
            default: begin
                if (is_sync) begin
                    n_type    = '0;
                    n_len_bad = 1'b0;
                    n_crc_bad = 1'b0;
                    n_decl    = '0;
                    n_raw     = 13'd1;
                    n_kept    = '0;
                    n_crc     = i_cfg.crc_seed;
                    n_crc_dig = '0;
                    n_phase   = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_type    <= '0;
            r_len_bad <= 1'b0;
            r_crc_bad <= 1'b0;
            r_decl    <= '0;
            r_raw     <= '0;
            r_kept    <= '0;
            r_crc     <= sefp_pkg::CRC_START_RESET;
            r_crc_dig <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len_bad <= n_len_bad;
            r_crc_bad <= n_crc_bad;
            r_decl    <= n_decl;
            r_raw     <= n_raw;
            r_kept    <= n_kept;
            r_crc     <= n_crc;
            r_crc_dig <= n_crc_dig;
        end
    end

`ifndef ASSERT_OFF
    a_crc3_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CRC3) |-> o_res_valid)
        else $error("no result at end of crc field");

    a_end_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind != sefp_pkg::KIND_PAYLOAD)
        |=> (r_phase == PH_DONE || r_phase == PH_ERROR))
        else $error("frame end did not park the parser");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_ESC) |-> (r_decl >= sefp_pkg::MIN_FRAME_LEN))
        else $error("payload phase with short declared length");

    a_keep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == sefp_pkg::KIND_PAYLOAD) |-> (n_kept <= KEEP_LIMIT))
        else $error("payload word beyond keep limit");
`endif

endmodule

// ===== sv/sync_escaped_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_escaped_frame_parser
// Byte-stuffed frame parser with CRC-16 (0x1021) check, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle on i_rx, unless o_res is stalled, and returns
// at most one result per byte on o_res: a payload byte, a frame-complete
// report with the received and computed CRC, or a frame error. Throughput is
// one byte per clock while o_res is not stalled; a result passes through the
// input register, then the result register. The throughput is set by the
// parse step, whose longest path is one byte-wide CRC-16 update. Configuration
// writes belong to idle periods; crc_start applies from the next frame start.
module sync_escaped_frame_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    sefp_byte_if.sink             i_rx,
    sefp_result_if.source         o_res
);

    logic [7:0]        r_sync;
    logic [11:0]       r_max_len;
    logic [15:0]       r_crc_start;
    logic [15:0]       r_crc_seed;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    sefp_pkg::t_result r_out;

    logic              advance;
    logic              res_valid;
    sefp_pkg::t_result res;
    sefp_pkg::t_cfg    cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= sefp_pkg::SYNC_RESET;
            r_max_len   <= sefp_pkg::MAX_LEN_RESET;
            r_crc_start <= sefp_pkg::CRC_START_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sefp_pkg::CFG_SYNC_VALUE:    r_sync      <= i_cfg_data[7:0];
                sefp_pkg::CFG_MAX_FRAME_LEN: r_max_len   <= i_cfg_data[11:0];
                sefp_pkg::CFG_CRC_START:     r_crc_start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // crc after the opening sync word
    always_ff @(posedge i_clk) begin
        r_crc_seed <= sefp_pkg::crc_byte(r_crc_start, r_sync);
    end

    assign cfg.sync_value    = r_sync;
    assign cfg.max_frame_len = r_max_len;
    assign cfg.crc_seed      = r_crc_seed;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sefp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.data          = r_out.data;
    assign o_res.payload_count = r_out.payload_count;
    assign o_res.frame_len     = r_out.frame_len;
    assign o_res.crc_got       = r_out.crc_got;
    assign o_res.crc_calc      = r_out.crc_calc;
    assign o_res.crc_match     = r_out.crc_match;
    assign o_res.error_cause   = r_out.error_cause;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the sync-escaped frame parser.
// ----------------------------------------------------------------------------
// Raw byte words are built as frames with escapes, CRC fields and deliberate
// flaws, mixed with line noise, and fed through a valid/ready driver. Every
// accepted byte steps an in-bench parser model that queues the expected result
// words; the monitor checks each result word field by field. Register settings
// change between traffic phases, and the phases vary sender gaps and receiver
// stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [7:0] t_octet;

    typedef enum logic [3:0] {
        PS_IDLE, PS_TYPE, PS_LEN0, PS_LEN1, PS_LEN2, PS_BODY, PS_ESC,
        PS_CRC1, PS_CRC2, PS_CRC3, PS_DONE, PS_ERROR
    } t_parse_state;

    typedef enum int {
        FL_NONE, FL_CRC_VALUE, FL_LEN_HEX, FL_LEN_RANGE, FL_LEN_SHIFT, FL_CRC_HEX,
        FL_TRUNCATED
    } t_flaw;

    localparam int          PAYLOAD_CAP    = 1024;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          PRINT_CAP      = 40;
    localparam logic [4:0]  NOT_HEX        = 5'd16;
    localparam t_octet      CH_ZERO        = 8'h30;
    localparam t_octet      CH_UPPER_A     = 8'h41;
    localparam t_octet      CH_LOWER_A     = 8'h61;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    sefp_byte_if   rx_if ();
    sefp_result_if res_if ();

    sync_escaped_frame_parser #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    always #5 i_clk = ~i_clk;

    // register mirror
    t_octet        cfg_sync;
    logic [11:0]   cfg_max;
    logic [15:0]   cfg_seed;

    // parser model state
    t_parse_state  p_state;
    t_octet        p_type;
    logic [1:0]    p_flags;
    logic [11:0]   p_len;
    logic [12:0]   p_raw;
    logic [10:0]   p_kept;
    logic [15:0]   p_crc;
    logic [11:0]   p_crcdig;

    t_octet            rx_backlog[$];
    sefp_pkg::t_result results_due[$];
    int                queued_words;
    int                send_gap_pct;
    int                stall_pct;
    bit                hold_armed;
    bit                hold_taken;
    int                hold_left;
    int                quiet_cycles;
    int                mismatches;
    int                result_idx;

    function automatic logic [15:0] crc16_step(logic [15:0] acc, t_octet b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ sefp_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [4:0] nibble_of(t_octet c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return 5'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return 5'(c - CH_UPPER_A + 8'd10);
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return 5'(c - CH_LOWER_A + 8'd10);
        return NOT_HEX;
    endfunction

    function automatic void count_raw(t_octet b);
        p_crc = crc16_step(p_crc, b);
        p_raw = p_raw + 13'd1;
    endfunction

    function automatic void clear_parse();
        p_state  = PS_IDLE;
        p_type   = '0;
        p_flags  = '0;
        p_len    = '0;
        p_raw    = '0;
        p_kept   = '0;
        p_crc    = cfg_seed;
        p_crcdig = '0;
    endfunction

    function automatic void open_frame();
        clear_parse();
        count_raw(cfg_sync);
        p_state = PS_TYPE;
    endfunction

    function automatic void crc_digit(t_octet b);
        logic [4:0] v;
        v = nibble_of(b);
        if (v == NOT_HEX) begin
            p_flags[1] = 1'b1;
            v = '0;
        end
        p_crcdig = {p_crcdig[7:0], v[3:0]};
    endfunction

    function automatic bit keep_payload(t_octet b, output sefp_pkg::t_result r);
        r = '0;
        if (p_kept >= PAYLOAD_CAP) return 1'b0;
        p_kept      = p_kept + 11'd1;
        r.kind      = sefp_pkg::KIND_PAYLOAD;
        r.data      = b;
        r.frame_len = p_len;
        return 1'b1;
    endfunction

    // steps the parser model by one byte; returns 1 when a result word is due
    function automatic bit parse_byte(t_octet b, output sefp_pkg::t_result r);
        logic [4:0]  v;
        logic [15:0] got;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        case (p_state) inside
            PS_TYPE: begin
                p_type = b;
                count_raw(b);
                p_state = PS_LEN0;
            end
            PS_LEN0, PS_LEN1, PS_LEN2: begin
                v = nibble_of(b);
                count_raw(b);
                if (v == NOT_HEX) begin
                    p_flags[0] = 1'b1;
                    v = '0;
                end
                p_len = {p_len[7:0], v[3:0]};
                if (p_state == PS_LEN0) begin
                    p_state = PS_LEN1;
                end else if (p_state == PS_LEN1) begin
                    p_state = PS_LEN2;
                end else if (p_flags[0]) begin
                    p_len         = '0;
                    p_state       = PS_ERROR;
                    hit           = 1'b1;
                    r.kind        = sefp_pkg::KIND_ERROR;
                    r.data        = p_type;
                    r.error_cause = sefp_pkg::CAUSE_LEN_HEX;
                end else if (p_len < sefp_pkg::MIN_FRAME_LEN || p_len > cfg_max) begin
                    p_state       = PS_ERROR;
                    hit           = 1'b1;
                    r.kind        = sefp_pkg::KIND_ERROR;
                    r.data        = p_type;
                    r.frame_len   = p_len;
                    r.error_cause = sefp_pkg::CAUSE_LEN_RANGE;
                end else begin
                    p_state = PS_BODY;
                end
            end
            PS_BODY: begin
                if (int'(p_raw) >= int'(p_len) - 4) begin
                    crc_digit(b);
                    p_state = PS_CRC1;
                end else begin
                    count_raw(b);
                    if (b == cfg_sync) begin
                        p_state = PS_ESC;
                    end else begin
                        hit = keep_payload(b, r);
                    end
                end
            end
            PS_ESC: begin
                if (b == cfg_sync) begin
                    count_raw(b);
                    p_state = PS_BODY;
                    hit = keep_payload(b, r);
                end else begin
                    // lone sync: it opens a new frame and this byte is its type
                    open_frame();
                    p_type = b;
                    count_raw(b);
                    p_state = PS_LEN0;
                end
            end
            PS_CRC1: begin
                crc_digit(b);
                p_state = PS_CRC2;
            end
            PS_CRC2: begin
                crc_digit(b);
                p_state = PS_CRC3;
            end
            PS_CRC3: begin
                v   = nibble_of(b);
                hit = 1'b1;
                r.data      = p_type;
                r.frame_len = p_len;
                if (v == NOT_HEX || p_flags[1]) begin
                    p_state       = PS_ERROR;
                    r.kind        = sefp_pkg::KIND_ERROR;
                    r.error_cause = sefp_pkg::CAUSE_CRC_HEX;
                end else begin
                    got         = {p_crcdig, v[3:0]};
                    p_state     = PS_DONE;
                    r.kind      = sefp_pkg::KIND_DONE;
                    r.crc_got   = got;
                    r.crc_calc  = p_crc;
                    r.crc_match = (got == p_crc);
                end
            end
            default: begin
                if (b == cfg_sync) open_frame();
            end
        endcase
        if (hit) r.payload_count = p_kept;
        return hit;
    endfunction

    // ------------------------------------------------------------------ stimulus

    function automatic t_octet hex_char(logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + t_octet'(n);
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + t_octet'(n) - 8'd10;
    endfunction

    function automatic t_octet bad_hex_char();
        t_octet c;
        do c = t_octet'($urandom_range(255)); while (nibble_of(c) != NOT_HEX);
        return c;
    endfunction

    task automatic offer(input t_octet b);
        rx_backlog.push_back(b);
        queued_words++;
    endtask

    task automatic queue_frame(input t_octet ftype, input t_octet body[$], input t_flaw flaw);
        t_octet      raw[$];
        logic [11:0] flen;
        logic [15:0] crc;
        int          n_esc;
        int          cut;
        n_esc = 0;
        // an escape pair at the very end lets a short length straddle the crc field
        if (flaw == FL_LEN_SHIFT && $urandom_range(1)) body.push_back(cfg_sync);
        foreach (body[i]) n_esc += (body[i] == cfg_sync) ? 2 : 1;
        flen = 12'(n_esc + 9);
        if (flaw == FL_LEN_SHIFT) flen = $urandom_range(1) ? flen - 12'd1 : flen + 12'd1;
        if (flaw == FL_LEN_RANGE) begin
            if (cfg_max < 12'd4095 && $urandom_range(1)) begin
                flen = 12'($urandom_range(int'(cfg_max) + 1, 4095));
            end else begin
                flen = 12'($urandom_range(8));
            end
        end
        raw = {cfg_sync, ftype, hex_char(flen[11:8]), hex_char(flen[7:4]), hex_char(flen[3:0])};
        if (flaw == FL_LEN_HEX) raw[$urandom_range(2, 4)] = bad_hex_char();
        if (flaw != FL_LEN_HEX && flaw != FL_LEN_RANGE) begin
            foreach (body[i]) begin
                raw.push_back(body[i]);
                if (body[i] == cfg_sync) raw.push_back(body[i]);
            end
            crc = cfg_seed;
            foreach (raw[i]) crc = crc16_step(crc, raw[i]);
            if (flaw == FL_CRC_VALUE) crc ^= 16'($urandom_range(1, 65535));
            for (int k = 3; k >= 0; k--) raw.push_back(hex_char(crc[4*k +: 4]));
            if (flaw == FL_CRC_HEX) raw[raw.size() - 1 - $urandom_range(3)] = bad_hex_char();
            if (flaw == FL_TRUNCATED) begin
                cut = $urandom_range(5, raw.size() - 5);
                while (raw.size() > cut) void'(raw.pop_back());
            end
        end
        foreach (raw[i]) offer(raw[i]);
    endtask

    task automatic queue_random_frame(input int body_len);
        t_octet body[$];
        int     n;
        int     room;
        int     pick;
        t_flaw  flaw;
        n = body_len;
        if (n < 0) n = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(16);
        room = (int'(cfg_max) - 9) / 2;
        if (n > room) n = room;
        repeat (n) begin
            body.push_back(($urandom_range(5) == 0) ? cfg_sync : t_octet'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (body_len >= 0 || pick < 55) flaw = FL_NONE;
        else if (pick < 63)             flaw = FL_CRC_VALUE;
        else if (pick < 69)             flaw = FL_LEN_HEX;
        else if (pick < 75)             flaw = FL_LEN_RANGE;
        else if (pick < 83)             flaw = FL_LEN_SHIFT;
        else if (pick < 89)             flaw = FL_CRC_HEX;
        else                            flaw = FL_TRUNCATED;
        // line noise between frames
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) offer(t_octet'($urandom_range(255)));
        end
        queue_frame(t_octet'($urandom_range(255)), body, flaw);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            sefp_pkg::CFG_SYNC_VALUE:    cfg_sync = val[7:0];
            sefp_pkg::CFG_MAX_FRAME_LEN: cfg_max  = val[11:0];
            sefp_pkg::CFG_CRC_START:     cfg_seed = val;
            default: ;
        endcase
    endtask

    task automatic drain_block();
        do @(posedge i_clk); while (rx_backlog.size() != 0 || rx_if.valid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_octet sync, input logic [11:0] maxlen,
                             input logic [15:0] seed, input int gap, input int stall,
                             input int budget, input bit with_hold, input bit with_big);
        int base;
        write_reg(sefp_pkg::CFG_SYNC_VALUE, {8'h00, sync});
        write_reg(sefp_pkg::CFG_MAX_FRAME_LEN, {4'h0, maxlen});
        write_reg(sefp_pkg::CFG_CRC_START, seed);
        send_gap_pct = gap;
        stall_pct    = stall;
        hold_armed   = with_hold;
        base = queued_words;
        if (with_big) queue_random_frame(PAYLOAD_CAP + 6);
        while (queued_words - base < budget) queue_random_frame(-1);
        drain_block();
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_idx, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------ driver

    always @(posedge i_clk) begin : drive
        sefp_pkg::t_result res;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                if (parse_byte(rx_if.rx_byte, res)) results_due.push_back(res);
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_backlog.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver side ready, with the long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_armed && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------ monitor

    always @(posedge i_clk) begin : monitor
        sefp_pkg::t_result seen;
        sefp_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen = {res_if.kind, res_if.data, res_if.payload_count, res_if.frame_len,
                    res_if.crc_got, res_if.crc_calc, res_if.crc_match, res_if.error_cause};
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected, kind %0d",
                                          result_idx, seen.kind));
            end else begin
                want = results_due.pop_front();
                check_field("kind", seen.kind, want.kind);
                check_field("data", seen.data, want.data);
                check_field("payload_count", seen.payload_count, want.payload_count);
                check_field("frame_len", seen.frame_len, want.frame_len);
                check_field("crc_got", seen.crc_got, want.crc_got);
                check_field("crc_calc", seen.crc_calc, want.crc_calc);
                check_field("crc_match", seen.crc_match, want.crc_match);
                check_field("error_cause", seen.error_cause, want.error_cause);
            end
            result_idx++;
        end
    end

    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_escaped_frame_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------ sequence

    initial begin : stimulus
        t_octet body[$];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sefp_pkg::CFG_SYNC_VALUE;
        i_cfg_data    = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        cfg_sync      = sefp_pkg::SYNC_RESET;
        cfg_max       = sefp_pkg::MAX_LEN_RESET;
        cfg_seed      = sefp_pkg::CRC_START_RESET;
        send_gap_pct  = 0;
        stall_pct     = 0;
        clear_parse();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: escapes, byte extremes, shortest frame and each error cause
        body = {sefp_pkg::SYNC_RESET, 8'hFF, 8'h00};
        queue_frame(8'h00, body, FL_NONE);
        body.delete();
        queue_frame(8'hFF, body, FL_LEN_RANGE);
        queue_frame(8'h7E, body, FL_LEN_HEX);
        queue_frame(8'h80, body, FL_CRC_HEX);
        drain_block();

        run_phase(sefp_pkg::SYNC_RESET, sefp_pkg::MAX_LEN_RESET, sefp_pkg::CRC_START_RESET,
                  0, 0, 48, 1'b0, 1'b0);
        run_phase(8'h00, 12'd60, 16'h0000, 64, 0, 48, 1'b0, 1'b0);
        run_phase(8'hFF, 12'd4095, 16'($urandom_range(65535)), 0, 64, 48, 1'b1, 1'b0);
        run_phase(t_octet'($urandom_range(255)), 12'($urandom_range(2600, 4094)),
                  16'($urandom_range(65535)), 8, 8, 48, 1'b0, 1'b1);
        run_phase(t_octet'($urandom_range(255)), sefp_pkg::MIN_FRAME_LEN,
                  16'($urandom_range(65535)), 0, 0, 24, 1'b0, 1'b0);

        if (results_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
        end
        if (mismatches == 0) begin
            $display("sync_escaped_frame_parser regression: pass");
        end else begin
            $display("sync_escaped_frame_parser regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sefp_pkg.sv
sv/sefp_byte_if.sv
sv/sefp_result_if.sv
sv/sefp_parser.sv
sv/sync_escaped_frame_parser.sv
tb/sv/tb_top.sv
